// ===== src/sha1_message_digest_unit_assert.svh =====
// Assertion macros shared by the SHA-1 digest unit modules.
// Expects clk and rst_n in the scope of use.
`ifndef SHA1_MESSAGE_DIGEST_UNIT_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_UNIT_ASSERT_SVH

// same-cycle implication
`define SHA1MDU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SHA1MDU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sha1mdu_pkg.sv =====
// Types, constants and round helpers for the SHA-1 digest unit.
// No dependencies.
package sha1mdu_pkg;

  localparam int QDEPTH = 4;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hefcdab89;
  localparam logic [31:0] H2_INIT = 32'h98badcfe;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hc3d2e1f0;

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;
  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [2:0] LAST_WORD_IDX = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_data;
    logic       last_byte;
  } sha1mdu_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha1mdu_out_t;

  typedef enum logic [1:0] {
    OP_BYTE,
    OP_END,
    OP_BYTE_END
  } sha1mdu_op_t;

  typedef struct packed {
    sha1mdu_op_t op;
    logic [7:0]  data;
  } sha1mdu_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } sha1mdu_state_t;

  typedef enum logic [1:0] {
    PH_MARK,
    PH_ZERO,
    PH_LEN
  } sha1mdu_phase_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

endpackage

// ===== src/sha1mdu_front.sv =====
// Front end: classifies input items and queues commands for the core.
// Depends on sha1mdu_pkg.
module sha1mdu_front #(
  parameter int DEPTH = sha1mdu_pkg::QDEPTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  sha1mdu_pkg::sha1mdu_in_t  in_item,
  output logic                      full,
  output logic                      cmd_valid,
  output sha1mdu_pkg::sha1mdu_cmd_t cmd,
  input  logic                      cmd_take
);
  import sha1mdu_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sha1mdu_cmd_t q_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          wr_en, rd_en;
  sha1mdu_cmd_t  new_cmd;

  assign full      = (cnt_r == CW'(DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign rd_en     = cmd_valid && cmd_take;
  assign wr_en     = push && !full && (in_item.has_data || in_item.last_byte);

  always_comb begin
    new_cmd.data = in_item.data_byte;
    if (in_item.has_data && in_item.last_byte) begin
      new_cmd.op = OP_BYTE_END;
    end else if (in_item.has_data) begin
      new_cmd.op = OP_BYTE;
    end else begin
      new_cmd.op = OP_END;
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_r + 1'b1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_r + 1'b1);
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = CW'(cnt_r + 1'b1);
    end else if (rd_en && !wr_en) begin
      cnt_nxt = CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

`include "sha1_message_digest_unit_assert.svh"

  `SHA1MDU_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CW'(DEPTH), "queue count beyond depth")
  `SHA1MDU_ASSERT_NEXT(a_idle_item_dropped, push && !full && !in_item.has_data && !in_item.last_byte && !cmd_take, cnt_r == $past(cnt_r), "empty item entered queue")
  `SHA1MDU_ASSERT_NEXT(a_push_counts, wr_en && !rd_en, cnt_r == CW'($past(cnt_r) + 1'b1), "accepted item not counted")

endmodule

// ===== src/sha1mdu_core.sv =====
// Back end: block buffer with message schedule, round engine, padding
// and digest output. Depends on sha1mdu_pkg.
module sha1mdu_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cmd_valid,
  input  sha1mdu_pkg::sha1mdu_cmd_t cmd,
  output logic                      cmd_take,
  output logic                      empty,
  input  logic                      pop,
  output sha1mdu_pkg::sha1mdu_out_t out_item
);
  import sha1mdu_pkg::*;

  sha1mdu_state_t state_r, state_nxt;
  sha1mdu_phase_t phase_r, phase_nxt;

  logic [511:0] blk_r, blk_nxt;
  logic [5:0]   fill_r, fill_nxt;
  logic [63:0]  len_r, len_nxt;
  logic [2:0]   len_cnt_r, len_cnt_nxt;
  logic         pad_r, pad_nxt;
  logic         pad_done_r, pad_done_nxt;
  logic [6:0]   rnd_r, rnd_nxt;
  logic [2:0]   idx_r, idx_nxt;
  logic [31:0]  chain_r [5];
  logic [31:0]  chain_nxt [5];
  logic [31:0]  a_r, b_r, c_r, d_r, e_r;
  logic [31:0]  a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;

  logic         push_en, count_bits, len_step, blk_full, last_pop;
  logic [7:0]   push_byte;
  logic [31:0]  w_cur, w_new, f_val, k_val, t_val;

  assign w_cur    = blk_r[511:480];
  assign w_new    = rotl(blk_r[95:64] ^ blk_r[255:224] ^ blk_r[447:416] ^ blk_r[511:480], 1);
  assign blk_full = push_en && (fill_r == 6'd63);
  assign last_pop = (state_r == ST_OUT) && pop && (idx_r == LAST_WORD_IDX);

  always_comb begin
    if (rnd_r inside {[7'd0:7'd19]}) begin
      f_val = (b_r & c_r) | (~b_r & d_r);
      k_val = K0;
    end else if (rnd_r inside {[7'd20:7'd39]}) begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = K1;
    end else if (rnd_r inside {[7'd40:7'd59]}) begin
      f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k_val = K2;
    end else begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = K3;
    end
  end

  assign t_val = rotl(a_r, 5) + f_val + e_r + k_val + w_cur;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (blk_full) begin
            state_nxt = ST_ROUND;
          end else if (cmd.op != OP_BYTE) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (blk_full) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rnd_r == LAST_ROUND) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        if (pad_done_r) begin
          state_nxt = ST_OUT;
        end else if (pad_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (last_pop) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // byte source and handshakes
  always_comb begin
    push_en    = 1'b0;
    push_byte  = cmd.data;
    cmd_take   = 1'b0;
    count_bits = 1'b0;
    len_step   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_take = 1'b1;
          if (cmd.op != OP_END) begin
            push_en    = 1'b1;
            count_bits = 1'b1;
          end
        end
      end
      ST_PAD: begin
        push_en = 1'b1;
        if (phase_r == PH_MARK) begin
          push_byte = PAD_MARK;
        end else if (phase_r == PH_ZERO && fill_r != LEN_POS) begin
          push_byte = 8'h00;
        end else begin
          push_byte = len_r[63:56];
          len_step  = 1'b1;
        end
      end
      default: begin
        push_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    empty                = (state_r != ST_OUT);
    out_item.word_index  = idx_r;
    out_item.last_word   = (idx_r == LAST_WORD_IDX);
    case (idx_r)
      3'd0:    out_item.digest_word = chain_r[0];
      3'd1:    out_item.digest_word = chain_r[1];
      3'd2:    out_item.digest_word = chain_r[2];
      3'd3:    out_item.digest_word = chain_r[3];
      default: out_item.digest_word = chain_r[4];
    endcase
  end

  // datapath next values
  always_comb begin
    blk_nxt      = blk_r;
    fill_nxt     = fill_r;
    len_nxt      = len_r;
    len_cnt_nxt  = len_cnt_r;
    pad_nxt      = pad_r;
    pad_done_nxt = pad_done_r;
    phase_nxt    = phase_r;
    rnd_nxt      = rnd_r;
    idx_nxt      = idx_r;
    chain_nxt    = chain_r;
    a_nxt = a_r; b_nxt = b_r; c_nxt = c_r; d_nxt = d_r; e_nxt = e_r;

    if (push_en) begin
      blk_nxt  = {blk_r[503:0], push_byte};
      fill_nxt = 6'(fill_r + 6'd1);
    end else if (state_r == ST_ROUND) begin
      blk_nxt = {blk_r[479:0], w_new};
    end

    if (count_bits) begin
      len_nxt = 64'(len_r + 64'd8);
    end else if (len_step) begin
      len_nxt = {len_r[55:0], 8'h00};
    end

    if (state_r == ST_IDLE && cmd_valid && cmd.op != OP_BYTE) begin
      pad_nxt   = 1'b1;
      phase_nxt = PH_MARK;
    end else if (state_r == ST_PAD) begin
      if (phase_r == PH_MARK) begin
        phase_nxt = PH_ZERO;
      end else if (len_step) begin
        phase_nxt = PH_LEN;
      end
    end

    if (len_step) begin
      len_cnt_nxt = 3'(len_cnt_r + 3'd1);
      if (len_cnt_r == 3'd7) begin
        pad_done_nxt = 1'b1;
      end
    end

    if (blk_full) begin
      a_nxt   = chain_r[0];
      b_nxt   = chain_r[1];
      c_nxt   = chain_r[2];
      d_nxt   = chain_r[3];
      e_nxt   = chain_r[4];
      rnd_nxt = '0;
    end else if (state_r == ST_ROUND) begin
      a_nxt   = t_val;
      b_nxt   = a_r;
      c_nxt   = rotl(b_r, 30);
      d_nxt   = c_r;
      e_nxt   = d_r;
      rnd_nxt = 7'(rnd_r + 7'd1);
    end

    if (state_r == ST_ADD) begin
      chain_nxt[0] = chain_r[0] + a_r;
      chain_nxt[1] = chain_r[1] + b_r;
      chain_nxt[2] = chain_r[2] + c_r;
      chain_nxt[3] = chain_r[3] + d_r;
      chain_nxt[4] = chain_r[4] + e_r;
    end

    if (state_r == ST_OUT && pop) begin
      idx_nxt = 3'(idx_r + 3'd1);
    end
    if (last_pop) begin
      idx_nxt      = '0;
      pad_nxt      = 1'b0;
      pad_done_nxt = 1'b0;
      chain_nxt[0] = H0_INIT;
      chain_nxt[1] = H1_INIT;
      chain_nxt[2] = H2_INIT;
      chain_nxt[3] = H3_INIT;
      chain_nxt[4] = H4_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      phase_r    <= PH_MARK;
      fill_r     <= '0;
      len_r      <= '0;
      len_cnt_r  <= '0;
      pad_r      <= 1'b0;
      pad_done_r <= 1'b0;
      rnd_r      <= '0;
      idx_r      <= '0;
      chain_r[0] <= H0_INIT;
      chain_r[1] <= H1_INIT;
      chain_r[2] <= H2_INIT;
      chain_r[3] <= H3_INIT;
      chain_r[4] <= H4_INIT;
    end else begin
      state_r    <= state_nxt;
      phase_r    <= phase_nxt;
      fill_r     <= fill_nxt;
      len_r      <= len_nxt;
      len_cnt_r  <= len_cnt_nxt;
      pad_r      <= pad_nxt;
      pad_done_r <= pad_done_nxt;
      rnd_r      <= rnd_nxt;
      idx_r      <= idx_nxt;
      chain_r    <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    d_r   <= d_nxt;
    e_r   <= e_nxt;
  end

`include "sha1_message_digest_unit_assert.svh"

  `SHA1MDU_ASSERT_NOW(a_round_bound, state_r == ST_ROUND, rnd_r <= LAST_ROUND, "round count past last round")
  `SHA1MDU_ASSERT_NOW(a_out_clean, state_r == ST_OUT, fill_r == 6'd0 && len_r == 64'd0 && idx_r <= LAST_WORD_IDX, "digest shown with stale block state")
  `SHA1MDU_ASSERT_NOW(a_no_take_busy, cmd_take, state_r == ST_IDLE, "command taken while core busy")
  `SHA1MDU_ASSERT_NEXT(a_chain_restart, last_pop, chain_r[0] == H0_INIT && chain_r[4] == H4_INIT && state_r == ST_IDLE, "chain not restarted after digest")

endmodule

// ===== src/sha1_message_digest_unit.sv =====
// Channel   | ports                        | accepted when
// ----------+------------------------------+------------------------
// input     | push, full, in_item          | push && !full
// result    | empty, pop, out_item         | pop && !empty
//
// The core takes a byte item when idle; every 64th byte adds a compression (80 rounds, chain add).
// An end item adds padding, one byte per cycle while not compressing, and one or two compressions before output.
// The five digest words then wait for pop; new items keep queueing meanwhile.
// The command queue holds QUEUE_DEPTH items; full rises only when it is full.
// Reset is synchronous, active low, and restores the initial chaining value.
// Top level of the SHA-1 digest unit. Depends on sha1mdu_pkg, sha1mdu_front, sha1mdu_core.
module sha1_message_digest_unit #(
  parameter int QUEUE_DEPTH = sha1mdu_pkg::QDEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  sha1mdu_pkg::sha1mdu_in_t in_item,
  output logic                     full,
  output logic                     empty,
  input  logic                     pop,
  output sha1mdu_pkg::sha1mdu_out_t out_item
);
  import sha1mdu_pkg::*;

  logic         cmd_valid;
  logic         cmd_take;
  sha1mdu_cmd_t cmd;

  sha1mdu_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_item  (in_item),
    .full     (full),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_take (cmd_take)
  );

  sha1mdu_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_take (cmd_take),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule
